@@ src/utf16_to_utf8_transcoder_top_macros.svh @@
// assertion macros shared by the transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define U16U8_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/u16u8_pkg.sv @@
// types, constants and the byte encoder of the utf-16 to utf-8 transcoder
package u16u8_pkg;

  // surrogate tags in code unit bits [15:10]
  localparam logic [5:0] HI_SUR_TAG = 6'h36;
  localparam logic [5:0] LO_SUR_TAG = 6'h37;

  // utf-8 lead and continuation prefixes
  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] LEAD_4 = 8'hF0;
  localparam logic [7:0] CONT   = 8'h80;

  // supplementary plane offset
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // byte count codes, stored as count minus one
  localparam logic [1:0] NB_1 = 2'd0;
  localparam logic [1:0] NB_2 = 2'd1;
  localparam logic [1:0] NB_3 = 2'd2;
  localparam logic [1:0] NB_4 = 2'd3;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic       error;
  } out_item_t;

  // one queued job: the bytes of a code point or one error
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      nbytes_m1;
    logic            last;
    logic            err;
  } job_t;

  // build the utf-8 bytes of one code point
  function automatic job_t encode_cp(logic [20:0] cp, logic last);
    job_t j;
    j.bytes     = '0;
    j.last      = last;
    j.err       = 1'b0;
    if (cp < 21'h80) begin
      j.nbytes_m1 = NB_1;
      j.bytes[0]  = cp[7:0];
    end else if (cp < 21'h800) begin
      j.nbytes_m1 = NB_2;
      j.bytes[0]  = LEAD_2 | {3'b0, cp[10:6]};
      j.bytes[1]  = CONT | {2'b0, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      j.nbytes_m1 = NB_3;
      j.bytes[0]  = LEAD_3 | {4'b0, cp[15:12]};
      j.bytes[1]  = CONT | {2'b0, cp[11:6]};
      j.bytes[2]  = CONT | {2'b0, cp[5:0]};
    end else begin
      j.nbytes_m1 = NB_4;
      j.bytes[0]  = LEAD_4 | {5'b0, cp[20:18]};
      j.bytes[1]  = CONT | {2'b0, cp[17:12]};
      j.bytes[2]  = CONT | {2'b0, cp[11:6]};
      j.bytes[3]  = CONT | {2'b0, cp[5:0]};
    end
    return j;
  endfunction

  // one error job, which always closes the string
  function automatic job_t error_job();
    job_t j;
    j.bytes     = '0;
    j.nbytes_m1 = NB_1;
    j.last      = 1'b1;
    j.err       = 1'b1;
    return j;
  endfunction

endpackage

@@ src/u16u8_front.sv @@
// front end: accepts code units, tracks surrogates and failed strings, builds jobs
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u16u8_pkg::in_item_t in_item,
  output logic                push_valid,
  input  logic                push_ready,
  output u16u8_pkg::job_t     push_job
);

  logic       pending_r, pending_nxt;
  logic       failed_r, failed_nxt;
  logic [9:0] hi_bits_r, hi_bits_nxt;
  logic       accept;
  logic       is_hi, is_lo;
  logic [20:0] pair_cp;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign is_hi    = (in_item.code_unit[15:10] == u16u8_pkg::HI_SUR_TAG);
  assign is_lo    = (in_item.code_unit[15:10] == u16u8_pkg::LO_SUR_TAG);
  assign pair_cp  = {1'b0, hi_bits_r, in_item.code_unit[9:0]} + u16u8_pkg::SUPP_BASE;

  // classify the unit and update surrogate state
  always_comb begin
    pending_nxt = pending_r;
    failed_nxt  = failed_r;
    hi_bits_nxt = hi_bits_r;
    push_valid  = 1'b0;
    push_job    = u16u8_pkg::encode_cp({5'b0, in_item.code_unit}, in_item.last_unit);
    if (accept) begin
      priority if (failed_r) begin
        if (in_item.last_unit) begin
          failed_nxt  = 1'b0;
          pending_nxt = 1'b0;
          hi_bits_nxt = '0;
        end
      end else if (pending_r) begin
        pending_nxt = 1'b0;
        hi_bits_nxt = '0;
        push_valid  = 1'b1;
        if (is_lo) begin
          push_job = u16u8_pkg::encode_cp(pair_cp, in_item.last_unit);
        end else begin
          push_job   = u16u8_pkg::error_job();
          failed_nxt = !in_item.last_unit;
        end
      end else if (is_hi && !in_item.last_unit) begin
        pending_nxt = 1'b1;
        hi_bits_nxt = in_item.code_unit[9:0];
      end else if (is_hi || is_lo) begin
        push_valid = 1'b1;
        push_job   = u16u8_pkg::error_job();
        failed_nxt = !in_item.last_unit;
      end else begin
        push_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      failed_r  <= 1'b0;
      hi_bits_r <= '0;
    end else begin
      pending_r <= pending_nxt;
      failed_r  <= failed_nxt;
      hi_bits_r <= hi_bits_nxt;
    end
  end

  `include "utf16_to_utf8_transcoder_top_macros.svh"

  `U16U8_ASSERT(a_pend_fail_excl, pending_r, !failed_r, "surrogate pending in a failed string")
  `U16U8_ASSERT_NEXT(a_last_clears, accept && in_item.last_unit, !failed_r && !pending_r, "state kept past last unit")

endmodule

@@ src/u16u8_queue.sv @@
// short job queue between front and back
module u16u8_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  u16u8_pkg::job_t push_job,
  output logic            head_valid,
  input  logic            pop,
  output u16u8_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u16u8_pkg::job_t entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  `include "utf16_to_utf8_transcoder_top_macros.svh"

  `U16U8_ASSERT(a_count_bound, 1'b1, count_r <= FULL_CNT, "queue count above depth")

endmodule

@@ src/u16u8_back.sv @@
// back end: walks the bytes of the head job into the output register
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  u16u8_pkg::job_t      head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_item
);

  logic                 out_valid_r, out_valid_nxt;
  u16u8_pkg::out_item_t out_item_r, out_item_nxt;
  logic [1:0]           idx_r, idx_nxt;
  logic                 load, at_end;

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign at_end    = (idx_r == head_job.nbytes_m1);
  assign pop       = load && at_end;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // pick the next byte of the head job
  always_comb begin
    out_item_nxt.out_byte   = head_job.bytes[idx_r];
    out_item_nxt.run_last   = at_end;
    out_item_nxt.string_end = at_end && head_job.last;
    out_item_nxt.error      = head_job.err;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_end ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

  `include "utf16_to_utf8_transcoder_top_macros.svh"

  `U16U8_ASSERT(a_err_closes, out_valid_r && out_item_r.error, out_item_r.run_last && out_item_r.string_end && (out_item_r.out_byte == 8'h00), "error item not closing string")
  `U16U8_ASSERT(a_idx_bound, head_valid, idx_r <= head_job.nbytes_m1, "byte index past job length")

endmodule

@@ src/utf16_to_utf8_transcoder_top.sv @@
// top level of the utf-16 to utf-8 transcoder
// Usage:
//   in channel  : in_valid/in_ready carry one UTF-16 code unit and a last-unit
//                 flag per item.
//   out channel : out_valid/out_ready carry one UTF-8 byte per item, with
//                 run_last, string_end and error flags.
//   A code point gives 1 to 4 output items; a high surrogate waits for its low
//   half and gives none; a malformed surrogate sequence gives one error item
//   that ends the string, and later units up to the last-unit flag give none.
// Order: an accepted item's job is written into the job queue, and its first
//   byte is then loaded into the output register once that register is free.
// Throughput: one input item per cycle while results are single bytes and the
//   receiver does not stall; the N bytes of a code point are drained by the back
//   end, one byte per cycle from the job queue while the receiver takes them.
// Reset (rst_n low, synchronous) clears surrogate and failed-string state,
//   empties the queue and drops out_valid.
// When the receiver stalls, the output item holds, the queue fills
//   (QUEUE_DEPTH jobs), then in_ready falls until bytes drain.
module utf16_to_utf8_transcoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16u8_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_item
);

  logic            push_valid, push_ready;
  u16u8_pkg::job_t push_job;
  logic            head_valid, pop;
  u16u8_pkg::job_t head_job;

  // classify units
  u16u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // job queue
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  // emit bytes
  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

@@ tb/tb_utf16_to_utf8_transcoder_top.sv @@
// testbench of the utf-16 to utf-8 transcoder: directed table, random strings, byte predictor
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder_top;

  localparam int DIR_ROWS = 25;
  localparam int RANDOM_UNITS = 295;

  typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

  // one directed row: the unit, and optionally the bytes typed in by hand
  typedef struct packed {
    logic [15:0]                logic_pad_unused_never;
  } unused_t;

  typedef struct packed {
    logic [15:0]                unit;
    logic                       last;
    logic                       fixed;
    logic [2:0]                 n_fixed;
    u16u8_pkg::out_item_t [0:3] fixed_res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  u16u8_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  u16u8_pkg::out_item_t out_item;

  // predictor state
  logic [9:0] hs_bits = '0;
  logic       hs_pending = 1'b0;
  logic       str_failed = 1'b0;

  u16u8_pkg::out_item_t utf8_pending[$];
  int                   mismatches = 0;
  int                   live_units = 0;
  int                   send_idle = 0;
  int                   recv_idle = 0;
  idle_mode_t           idle_mode;
  dir_row_t             dir_rows [0:DIR_ROWS-1];

  utf16_to_utf8_transcoder_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic u16u8_pkg::out_item_t utf8_item(logic [7:0] b, logic rl, logic se,
                                                     logic er);
    return '{out_byte: b, run_last: rl, string_end: se, error: er};
  endfunction

  // bytes of one code point: lead byte then continuation bytes, high bits first
  function automatic void queue_code_point(logic [20:0] cp, logic l);
    int n_cont;
    logic [20:0] sh;
    logic [7:0] prefix;
    if (cp < 21'h80) begin
      utf8_pending.push_back(utf8_item(cp[7:0], 1'b1, l, 1'b0));
      return;
    end
    n_cont = (cp < 21'h800) ? 1 : (cp < 21'h10000) ? 2 : 3;
    prefix = 8'(8'hFF << (7 - n_cont));
    sh = cp >> (6 * n_cont);
    utf8_pending.push_back(utf8_item(prefix | sh[7:0], 1'b0, 1'b0, 1'b0));
    for (int k = n_cont - 1; k >= 0; k--) begin
      sh = cp >> (6 * k);
      utf8_pending.push_back(utf8_item(8'h80 | {2'b00, sh[5:0]}, k == 0, (k == 0) && l,
                                       1'b0));
    end
  endfunction

  // malformed surrogate: one error item closes the string
  function automatic void fail_string(logic l, bit record);
    hs_pending = 1'b0;
    hs_bits = '0;
    str_failed = !l;
    if (record) utf8_pending.push_back(utf8_item(8'h00, 1'b1, 1'b1, 1'b1));
  endfunction

  // advance the predictor by one unit; returns 1 when the unit is dropped
  function automatic bit predict_unit(logic [15:0] u, logic l, bit record);
    logic [20:0] cp;
    if (str_failed) begin
      if (l) begin
        str_failed = 1'b0;
        hs_pending = 1'b0;
        hs_bits = '0;
      end
      return 1'b1;
    end
    if (hs_pending) begin
      if (u < 16'hDC00 || u >= 16'hE000) begin
        fail_string(l, record);
        return 1'b0;
      end
      cp = 21'({hs_bits, u[9:0]}) + 21'h10000;
      hs_pending = 1'b0;
      hs_bits = '0;
      if (record) queue_code_point(cp, l);
      return 1'b0;
    end
    if (u >= 16'hD800 && u < 16'hE000) begin
      if (u >= 16'hDC00 || l) begin
        fail_string(l, record);
      end else begin
        hs_bits = u[9:0];
        hs_pending = 1'b1;
      end
      return 1'b0;
    end
    if (record) queue_code_point({5'b0, u}, l);
    return 1'b0;
  endfunction

  // offer one unit, hold it until accepted, then predict
  task automatic send_unit(input logic [15:0] u, input logic l, input bit record,
                           output bit dropped);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= '{code_unit: u, last_unit: l};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dropped = predict_unit(u, l, record);
  endtask

  // one random string, mostly well formed, with some broken surrogates
  task automatic send_random_string();
    logic [15:0] units[$];
    int n_cp;
    int pick;
    bit dropped;
    bit stop;
    n_cp = $urandom_range(1, 6);
    stop = 1'b0;
    for (int i = 0; i < n_cp && !stop; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        units.push_back(16'($urandom_range(0, 16'h7F)));
      end else if (pick < 55) begin
        units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
      end else if (pick < 70) begin
        if ($urandom_range(0, 1)) units.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
        else units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (pick < 88) begin
        units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (pick < 92) begin
        // lone low surrogate
        units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (pick < 96) begin
        // high surrogate followed by something other than a low one
        units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        if ($urandom_range(0, 1)) units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        else units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (pick < 98) begin
        // high surrogate closes the string
        units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
        stop = 1'b1;
      end else begin
        units.push_back(16'($urandom_range(0, 16'hFFFF)));
      end
    end
    foreach (units[i]) begin
      send_unit(units[i], i == units.size() - 1, 1'b1, dropped);
      if (!dropped) live_units++;
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare each accepted output item with the oldest predicted byte
  always @(posedge clk) begin : check_out
    u16u8_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_pending.size() == 0) begin
        $display("%0t: item expected none got %h", $time, out_item);
        mismatches++;
      end else begin
        want = utf8_pending.pop_front();
        check_field("out_byte", want.out_byte, out_item.out_byte);
        check_field("run_last", {7'b0, want.run_last}, {7'b0, out_item.run_last});
        check_field("string_end", {7'b0, want.string_end}, {7'b0, out_item.string_end});
        check_field("error", {7'b0, want.error}, {7'b0, out_item.error});
      end
    end
  end

  // stimulus
  initial begin : stim
    bit dropped;
    idle_mode_t next_mode;
    dir_rows = '{
      '{16'h0000, 1'b1, 1'b1, 3'd1, {utf8_item(8'h00, 1'b1, 1'b1, 1'b0), 33'b0}},
      '{16'h007F, 1'b0, 1'b1, 3'd1, {utf8_item(8'h7F, 1'b1, 1'b0, 1'b0), 33'b0}},
      '{16'h0080, 1'b0, 1'b1, 3'd2, {utf8_item(8'hC2, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'h80, 1'b1, 1'b0, 1'b0), 22'b0}},
      '{16'h07FF, 1'b0, 1'b1, 3'd2, {utf8_item(8'hDF, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'hBF, 1'b1, 1'b0, 1'b0), 22'b0}},
      '{16'h0800, 1'b0, 1'b1, 3'd3, {utf8_item(8'hE0, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'hA0, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'h80, 1'b1, 1'b0, 1'b0), 11'b0}},
      '{16'hFFFF, 1'b1, 1'b1, 3'd3, {utf8_item(8'hEF, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'hBF, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'hBF, 1'b1, 1'b1, 1'b0), 11'b0}},
      '{16'hD800, 1'b0, 1'b1, 3'd0, 44'b0},
      '{16'hDC00, 1'b0, 1'b1, 3'd4, {utf8_item(8'hF0, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'h90, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'h80, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'h80, 1'b1, 1'b0, 1'b0)}},
      '{16'hDBFF, 1'b0, 1'b1, 3'd0, 44'b0},
      '{16'hDFFF, 1'b1, 1'b1, 3'd4, {utf8_item(8'hF4, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'h8F, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'hBF, 1'b0, 1'b0, 1'b0),
                                     utf8_item(8'hBF, 1'b1, 1'b1, 1'b0)}},
      // lone low surrogate, then the rest of the string is dropped
      '{16'hDC00, 1'b0, 1'b1, 3'd1, {utf8_item(8'h00, 1'b1, 1'b1, 1'b1), 33'b0}},
      '{16'h0041, 1'b0, 1'b1, 3'd0, 44'b0},
      '{16'hD800, 1'b1, 1'b1, 3'd0, 44'b0},
      // high surrogate as the last unit
      '{16'hDBFF, 1'b1, 1'b1, 3'd1, {utf8_item(8'h00, 1'b1, 1'b1, 1'b1), 33'b0}},
      '{16'h0041, 1'b1, 1'b1, 3'd1, {utf8_item(8'h41, 1'b1, 1'b1, 1'b0), 33'b0}},
      // high surrogate then a plain unit
      '{16'hD800, 1'b0, 1'b1, 3'd0, 44'b0},
      '{16'h0041, 1'b0, 1'b1, 3'd1, {utf8_item(8'h00, 1'b1, 1'b1, 1'b1), 33'b0}},
      '{16'hFFFF, 1'b1, 1'b1, 3'd0, 44'b0},
      // high surrogate then another high surrogate
      '{16'hDBFF, 1'b0, 1'b1, 3'd0, 44'b0},
      '{16'hD800, 1'b0, 1'b1, 3'd1, {utf8_item(8'h00, 1'b1, 1'b1, 1'b1), 33'b0}},
      '{16'h1234, 1'b1, 1'b1, 3'd0, 44'b0},
      // high surrogate then a plain unit that ends the string
      '{16'hD800, 1'b0, 1'b1, 3'd0, 44'b0},
      '{16'hE000, 1'b1, 1'b1, 3'd1, {utf8_item(8'h00, 1'b1, 1'b1, 1'b1), 33'b0}},
      '{16'hAAAA, 1'b0, 1'b0, 3'd0, 44'b0},
      '{16'h5555, 1'b1, 1'b0, 3'd0, 44'b0}
    };

    idle_mode = IDLE_SEND_LIGHT;
    send_idle = 25;
    recv_idle = 82;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_unit(dir_rows[r].unit, dir_rows[r].last, !dir_rows[r].fixed, dropped);
      if (dir_rows[r].fixed) begin
        for (int k = 0; k < dir_rows[r].n_fixed; k++) begin
          utf8_pending.push_back(dir_rows[r].fixed_res[k]);
        end
      end
    end

    // random strings, idling changes in three stages
    while (live_units < RANDOM_UNITS) begin
      next_mode = (live_units < RANDOM_UNITS / 3) ? IDLE_SEND_LIGHT :
                  (live_units < 2 * RANDOM_UNITS / 3) ? IDLE_SEND_HEAVY : IDLE_NONE;
      if (next_mode != idle_mode) begin
        // hold off until every byte has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (utf8_pending.size() != 0);
        idle_mode = next_mode;
        case (idle_mode)
          IDLE_SEND_HEAVY: begin
            send_idle = 82;
            recv_idle = 25;
          end
          default: begin
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
      end
      send_random_string();
    end

    // drain
    in_valid <= 1'b0;
    do @(posedge clk); while (utf8_pending.size() != 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
